/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/mws_pkg.sv */
package mws_pkg;

    // Pattern storage and text limits
    localparam int PAT_MAX   = 16;
    localparam int MAX_TEXT  = 65536;
    localparam int PAT_IDX_W = $clog2(PAT_MAX);
    localparam int PLEN_W    = 5;
    localparam int POS_W     = $clog2(MAX_TEXT);
    localparam int LEN_W     = POS_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_BITS  = PAT_MAX * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    // Per-item control from the pipeline to the state holders
    typedef struct packed {
        logic upd;   // item is matched against the pattern
        logic clr;   // item closes the text; clear state afterwards
    } t_step;

    // Prefix match seen by the best-window tracker
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] start;
    } t_match;

endpackage

/* hdl/mws_prefix.sv */
module mws_prefix (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mws_pkg::t_step            i_step,
    input  logic [7:0]                i_text_byte,
    input  logic [mws_pkg::POS_W-1:0] i_pos,
    input  logic [mws_pkg::PAT_BITS-1:0] i_pattern,
    input  logic [mws_pkg::PLEN_W-1:0]   i_pattern_length,
    output mws_pkg::t_match           o_match
);
    import mws_pkg::*;

    logic [PAT_MAX-1:0] r_valid;
    logic [PAT_MAX-1:0] n_valid;
    logic [POS_W-1:0]   r_start [PAT_MAX];
    logic [POS_W-1:0]   n_start [PAT_MAX];
    logic [PLEN_W-1:0]  w_len;
    logic [PAT_IDX_W-1:0] w_idx;

    // Shift each prefix forward where its pattern byte matches
    always_comb begin
        for (int j = 0; j < PAT_MAX; j++) begin
            n_valid[j] = r_valid[j];
            n_start[j] = r_start[j];
            if (i_pattern[8*j +: 8] == i_text_byte) begin
                if (j == 0) begin
                    n_valid[j] = 1'b1;
                    n_start[j] = i_pos;
                end else begin
                    n_valid[j] = r_valid[j-1];
                    n_start[j] = r_start[j-1];
                end
            end
        end
    end

    // Clamp the length and pick the full-pattern entry
    assign w_len = (i_pattern_length > PLEN_W'(PAT_MAX)) ? PLEN_W'(PAT_MAX) : i_pattern_length;
    assign w_idx = PAT_IDX_W'(w_len - PLEN_W'(1));
    assign o_match.valid = (w_len != '0) && n_valid[w_idx];
    assign o_match.start = n_start[w_idx];

    // Hold prefix valid bits; drop them at the end of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clr) begin
            r_valid <= '0;
        end else if (i_step.upd) begin
            r_valid <= n_valid;
        end
    end

    // Prefix start positions need no reset
    always_ff @(posedge i_clk) begin
        if (i_step.upd) begin
            r_start <= n_start;
        end
    end

endmodule

/* hdl/mws_best.sv */
module mws_best (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_last,
    input  mws_pkg::t_match           i_match,
    output logic                      o_in_range,
    output logic [mws_pkg::POS_W-1:0] o_pos,
    output logic                      o_found,
    output logic [mws_pkg::POS_W-1:0] o_window_start,
    output logic [mws_pkg::LEN_W-1:0] o_window_length,
    output logic                      o_overflow
);
    import mws_pkg::*;

    logic [LEN_W-1:0] r_pos;
    logic [POS_W-1:0] r_best_start;
    logic [LEN_W-1:0] r_best_len;
    logic             r_ovf;
    logic [POS_W-1:0] n_best_start;
    logic [LEN_W-1:0] n_best_len;
    logic             n_ovf;
    logic [LEN_W-1:0] w_len;
    logic             w_take;

    assign o_in_range = (r_pos < LEN_W'(MAX_TEXT));
    assign o_pos      = r_pos[POS_W-1:0];

    // Window from the matched start through the current byte
    assign w_len  = LEN_W'(r_pos) - LEN_W'(i_match.start) + LEN_W'(1);
    assign w_take = i_adv && o_in_range && i_match.valid
                    && ((r_best_len == '0) || (w_len < r_best_len));

    // Keep only a strictly shorter window; overflow sticks once a byte is out of range
    always_comb begin
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        if (w_take) begin
            n_best_start = i_match.start;
            n_best_len   = w_len;
        end
        n_ovf = r_ovf || (i_adv && !o_in_range);
    end

    // Result fields include this item's update
    assign o_found         = (n_best_len != '0);
    assign o_window_start  = n_best_start;
    assign o_window_length = n_best_len;
    assign o_overflow      = n_ovf;

    // Advance position and best window; clear after a last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_pos        <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_ovf        <= 1'b0;
        end else if (i_adv) begin
            if (o_in_range) begin
                r_pos <= r_pos + LEN_W'(1);
            end
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_ovf        <= n_ovf;
        end
    end

endmodule

/* hdl/min_window_subsequence.sv */
// Shortest window of a byte stream holding the configured pattern as a subsequence.
// Input channel (i_in_valid/o_in_ready) carries one text byte per item, with
// i_last_byte marking the end of a text. Output channel (o_out_valid/i_out_ready)
// carries one result per text: found, window start, window length, overflow.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes pattern length (index 0)
// and pattern bytes 0-7 (index 1) and 8-15 (index 2); other indexes are ignored.
// o_cfg_ready is always high; write only while no text is in flight.
// Throughput: one byte per cycle unless a last byte is held back. A byte waits in
// the input register, where all 16 prefix entries update in parallel, and the result
// of a text is registered in the output register when its last byte is processed.
// A stalled receiver only holds back a last byte while the output register is
// full; other bytes keep flowing. Bytes past 65536 set overflow and are skipped.
// Reset (synchronous, active low) empties both registers, clears all match state
// and loads pattern length 1 with all-zero pattern bytes. No clearing pass is needed.
module min_window_subsequence (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [mws_pkg::POS_W-1:0]     o_window_start,
    output logic [mws_pkg::LEN_W-1:0]     o_window_length,
    output logic                          o_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mws_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    logic                  r_found;
    logic [POS_W-1:0]      r_start;
    logic [LEN_W-1:0]      r_length;
    logic                  r_ovf;
    logic [PLEN_W-1:0]     r_pat_len;
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic                  w_adv;
    logic                  w_in_range;
    logic [POS_W-1:0]      w_pos;
    t_step                 w_step;
    t_match                w_match;
    logic                  w_found;
    logic [POS_W-1:0]      w_start;
    logic [LEN_W-1:0]      w_length;
    logic                  w_ovf;

    // Process the held item unless it is a last item and the output is blocked
    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    assign w_step.upd = w_adv && w_in_range;
    assign w_step.clr = w_adv && r_in_last;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len  <= PLEN_W'(1);
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[PLEN_W-1:0];
                CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mws_prefix u_prefix (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_text_byte      (r_in_byte),
        .i_pos            (w_pos),
        .i_pattern        ({r_pat_high, r_pat_low}),
        .i_pattern_length (r_pat_len),
        .o_match          (w_match)
    );

    mws_best u_best (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_last          (r_in_last),
        .i_match         (w_match),
        .o_in_range      (w_in_range),
        .o_pos           (w_pos),
        .o_found         (w_found),
        .o_window_start  (w_start),
        .o_window_length (w_length),
        .o_overflow      (w_ovf)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_found  <= w_found;
            r_start  <= w_start;
            r_length <= w_length;
            r_ovf    <= w_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_window_start  = r_start;
    assign o_window_length = r_length;
    assign o_overflow      = r_ovf;

`include "assert_macros.svh"

    // A processed last item always leaves a result behind
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_adv && r_in_last, r_out_valid)
    // Position is back at zero after a text closes
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_adv && r_in_last, w_in_range && (w_pos == '0))
    // Found flag agrees with a nonzero window length
    `ASSERT_IMPLIES(a_found_len, i_clk, i_rst_n, r_out_valid, r_found == (r_length != '0))
    // A blocked output holds back a last item
    `ASSERT_IMPLIES(a_last_stalls, i_clk, i_rst_n, r_in_valid && r_in_last && r_out_valid && !i_out_ready, !w_adv)

endmodule

/* dv/tb_min_window_subsequence.sv */
module tb_min_window_subsequence;
    timeunit 1ns;
    timeprecision 1ps;

    import mws_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1120;
    localparam int LONG_TEXT    = 150;
    localparam int MAX_PRINTED  = 40;

    // One search result as the block reports it
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             overflow;
    } t_window;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte;
    logic                  i_last_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_found;
    logic [POS_W-1:0]      o_window_start;
    logic [LEN_W-1:0]      o_window_length;
    logic                  o_overflow;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Pattern registers as the block should hold them
    logic [PLEN_W-1:0]     pat_len;
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;

    // Match state of the search
    logic                  pfx_valid [PAT_MAX];
    logic [LEN_W-1:0]      pfx_start [PAT_MAX];
    logic [LEN_W-1:0]      text_pos;
    logic [POS_W-1:0]      best_start;
    logic [LEN_W-1:0]      best_len;
    logic                  ovf_seen;

    t_window pending_windows [$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      windows_checked = 0;
    logic    send_gaps = 1'b1;
    logic    recv_stalls = 1'b1;

    min_window_subsequence u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_text_byte     (i_text_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_window_start  (o_window_start),
        .o_window_length (o_window_length),
        .o_overflow      (o_overflow),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Drop all match state, as on reset and after a last byte
    task automatic clear_search();
        for (int j = 0; j < PAT_MAX; j++) begin
            pfx_valid[j] = 1'b0;
            pfx_start[j] = '0;
        end
        text_pos   = '0;
        best_start = '0;
        best_len   = '0;
        ovf_seen   = 1'b0;
    endtask

    function automatic logic [7:0] pattern_at(input int idx);
        if (idx < 8) begin
            return pat_lo[8*idx +: 8];
        end
        return pat_hi[8*(idx-8) +: 8];
    endfunction

    // Advance the search by one text byte; queue a window on a last byte
    task automatic step_window_search(input logic [7:0] b, input logic last);
        logic [LEN_W-1:0] p;
        logic [LEN_W-1:0] len;
        int               n;
        t_window          w;
        if (text_pos >= MAX_TEXT) begin
            ovf_seen = 1'b1;
        end else begin
            p = text_pos;
            n = pat_len;
            if (n > PAT_MAX) begin
                n = PAT_MAX;
            end
            // walk down so each entry sees the value from the previous byte
            for (int j = PAT_MAX - 1; j >= 0; j--) begin
                if (pattern_at(j) == b) begin
                    if (j == 0) begin
                        pfx_valid[0] = 1'b1;
                        pfx_start[0] = p;
                    end else begin
                        pfx_valid[j] = pfx_valid[j-1];
                        pfx_start[j] = pfx_start[j-1];
                    end
                end
            end
            if (n >= 1 && pfx_valid[n-1]) begin
                len = p - pfx_start[n-1] + 1'b1;
                if (best_len == 0 || len < best_len) begin
                    best_len   = len;
                    best_start = pfx_start[n-1][POS_W-1:0];
                end
            end
            text_pos = p + 1'b1;
        end
        if (last) begin
            w.found    = (best_len != 0);
            w.start    = best_start;
            w.length   = best_len;
            w.overflow = ovf_seen;
            pending_windows.push_back(w);
            clear_search();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("window %0d: %s got %0h want %0h", windows_checked, what, got, want);
        end
    endtask

    // Send one text byte; called and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_gaps && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        step_window_search(b, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the input until every queued window is out, then let the pipe empty
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_windows.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PATTERN_LENGTH: pat_len = data[PLEN_W-1:0];
            CFG_PATTERN_LOW:    pat_lo  = data;
            CFG_PATTERN_HIGH:   pat_hi  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Filler byte: half from the small alphabet, half anything
    function automatic logic [7:0] text_noise(input logic [23:0] alph);
        if ($urandom_range(1) == 0) begin
            return alph[8*$urandom_range(2) +: 8];
        end
        return 8'($urandom);
    endfunction

    // Receiver: stall at random while enabled
    always @(negedge i_clk) begin
        i_out_ready <= recv_stalls ? ($urandom_range(99) >= 28) : 1'b1;
    end

    // Compare each accepted result with the oldest queued window
    always @(posedge i_clk) begin : check_windows
        t_window want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_windows.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_window_length), 0);
            end else begin
                want = pending_windows.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_window_start !== want.start)
                    report_mismatch("start", 32'(o_window_start), 32'(want.start));
                if (o_window_length !== want.length)
                    report_mismatch("length", 32'(o_window_length), 32'(want.length));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_overflow), 32'(want.overflow));
            end
            windows_checked++;
        end
    end

    // Reset pattern: length 1, byte 0x00
    task automatic test_reset_pattern();
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Three-byte pattern; two equal windows, the earlier one must stay
    task automatic test_tie_keeps_first();
        write_reg(CFG_PATTERN_LENGTH, 64'd3);
        write_reg(CFG_PATTERN_LOW, 64'h0000_0000_00FF_5FA0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h5F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h5F, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Zero length never matches; an oversized length clamps to the full pattern
    task automatic test_length_limits();
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
        write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
        // an unused index must leave the pattern alone
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        for (int k = 0; k < PAT_MAX; k++) begin
            send_byte(pattern_at(k), k == PAT_MAX - 1);
        end
    endtask

    // Window spanning a long filler text, then a shorter window that must replace it
    task automatic test_widest_window();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0000_B2A1);
        send_byte(8'hA1, 1'b0);
        repeat (LONG_TEXT) send_byte(8'h33, 1'b0);
        send_byte(8'hB2, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(8'hB2, 1'b1);
        wait_quiet();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Only match on the final position; then a short text shows the clear
    task automatic test_last_position();
        logic [7:0] b;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        write_reg(CFG_PATTERN_LENGTH, {$urandom, $urandom_range(31) << PLEN_W | 32'd1});
        write_reg(CFG_PATTERN_LOW, {$urandom, 24'($urandom), 8'h5A});
        repeat (LONG_TEXT) begin
            do b = 8'($urandom); while (b == 8'h5A);
            send_byte(b, 1'b0);
        end
        send_byte(8'h5A, 1'b1);
        send_byte(8'h5A, 1'b1);
        wait_quiet();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Random settings; mostly texts that hold the pattern amid noise
    task automatic test_random_texts();
        logic [PAT_BITS-1:0]   pat_v;
        logic [23:0]           alph;
        logic [CFG_DATA_W-1:0] len_word;
        int                    first_item;
        int                    phase;
        int                    pick;
        int                    eff_n;
        int                    drop;
        int                    cnt;
        first_item = items_sent;
        phase = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            // pick a new setting
            alph = 24'($urandom);
            for (int k = 0; k < PAT_MAX; k++) begin
                pat_v[8*k +: 8] = ($urandom_range(9) < 8) ? alph[8*$urandom_range(2) +: 8]
                                                           : 8'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 5)       eff_n = 0;
            else if (pick < 12) eff_n = $urandom_range(17, 31);
            else if (pick < 20) eff_n = PAT_MAX;
            else                eff_n = $urandom_range(1, 6);
            len_word = {$urandom, $urandom};
            len_word[PLEN_W-1:0] = PLEN_W'(eff_n);
            write_reg(CFG_PATTERN_LENGTH, len_word);
            write_reg(CFG_PATTERN_LOW, pat_v[63:0]);
            write_reg(CFG_PATTERN_HIGH, pat_v[127:64]);
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            end
            if (eff_n > PAT_MAX) eff_n = PAT_MAX;
            send_gaps   = (phase != 3);
            recv_stalls = (phase != 3);
            repeat (8) begin
                if ($urandom_range(99) < 75) begin
                    // pattern embedded with noise, sometimes one byte dropped
                    drop = (eff_n > 1 && $urandom_range(3) == 0) ? $urandom_range(eff_n - 1)
                                                                 : -1;
                    for (int k = 0; k < eff_n; k++) begin
                        repeat ($urandom_range(2)) send_byte(text_noise(alph), 1'b0);
                        if (k != drop) send_byte(pat_v[8*k +: 8], 1'b0);
                    end
                    repeat ($urandom_range(3)) send_byte(text_noise(alph), 1'b0);
                    send_byte(text_noise(alph), 1'b1);
                end else begin
                    cnt = $urandom_range(1, 12);
                    for (int k = 0; k < cnt; k++) begin
                        send_byte(text_noise(alph), k == cnt - 1);
                    end
                end
                if ($urandom_range(9) == 0) wait_quiet();
            end
            phase++;
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_text_byte = '0;
        i_last_byte = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        pat_len     = PLEN_W'(1);
        pat_lo      = '0;
        pat_hi      = '0;
        clear_search();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_pattern();
        test_tie_keeps_first();
        test_length_limits();
        test_widest_window();
        test_last_position();
        test_random_texts();
        wait_quiet();

        if (mismatch_count == 0) begin
            $display("min_window_subsequence: match");
        end else begin
            $display("min_window_subsequence: mismatch");
        end
        $finish;
    end

    // Give up long after the slowest correct run would be done
    initial begin
        #8_000_000;
        $display("min_window_subsequence: mismatch");
        $finish;
    end

endmodule

/* min_window_subsequence.f */
+incdir+hdl
hdl/mws_pkg.sv
hdl/mws_prefix.sv
hdl/mws_best.sv
hdl/min_window_subsequence.sv
dv/tb_min_window_subsequence.sv
